FILE: design/otfm_pkg.sv
// Shared types and constants for the over-temperature fault monitor.
`default_nettype none

package otfm_pkg;

  localparam int TEMP_WIDTH_DEF = 16;
  localparam int TIME_WIDTH_DEF = 32;
  localparam int LOW_BAND       = -5;
  localparam int NUM_FAULTS     = 3;
  localparam int CFG_IDX_WIDTH  = 3;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_ELEK_LIMIT      = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_FLOOR1_LIMIT    = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_FLOOR2_LIMIT    = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_STOVE_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_FAULT_DELAY     = 3'd4;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_PELLET_MODE     = 3'd5;

  typedef enum logic [1:0] {
    FS_INACTIVE = 2'd0,
    FS_PRESENT  = 2'd1,
    FS_ACTIVE   = 2'd2
  } fault_state_e;

  typedef struct packed {
    logic update;
    logic clear;
    logic present;
    logic fire;
  } chan_ctrl_t;

endpackage

`default_nettype wire

FILE: design/overtemp_fault_monitor.sv
// Top level of the over-temperature fault monitor.
//
// Each request on the slave stream is one monitoring pass: a time stamp, three
// sensor readings with present flags, the stove reading, two valve flags and a
// clear mask. Each pass yields exactly one result request on the master stream
// with the three fault states and their recorded peaks.
// A request is registered on acceptance and its result is registered when the
// result register is free. While results are taken the block takes one request
// every cycle; a single compare-and-select stage between the two registers
// updates the fault and timer state. Limits, stove threshold, fault delay and
// pellet mode are written through the configuration port; the user must do so
// only while no request is in flight, as the block does not enforce this.
// Reset clears all faults, peaks and timers and loads the register defaults.
// When the receiver stalls, the result holds and the input register keeps one
// further request; after that s_axis_tready falls until the result is taken.
`default_nettype none

module overtemp_fault_monitor #(
  parameter int TEMP_WIDTH = otfm_pkg::TEMP_WIDTH_DEF,
  parameter int TIME_WIDTH = otfm_pkg::TIME_WIDTH_DEF,
  localparam int InBits    = TIME_WIDTH + 4 * (TEMP_WIDTH + 1) + 5,
  localparam int InW       = ((InBits + 7) / 8) * 8,
  localparam int OutBits   = 3 * (TEMP_WIDTH + 3),
  localparam int OutW      = ((OutBits + 7) / 8) * 8,
  localparam int CfgW      = (TIME_WIDTH > TEMP_WIDTH) ? TIME_WIDTH : TEMP_WIDTH
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [otfm_pkg::CFG_IDX_WIDTH-1:0]   cfg_idx_i,
  input  wire logic [CfgW-1:0]                      cfg_data_i,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // now, elek_temp, elek_present, floor1_temp, floor1_present, floor2_temp,
  // floor2_present, stove_temp, stove_present, valve1_open, valve2_open,
  // clear_mask
  input  wire logic [InW-1:0]                       s_axis_tdata,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // elek_state, floor1_state, floor2_state, elek_peak, floor1_peak,
  // floor2_peak, elek_peak_valid, floor1_peak_valid, floor2_peak_valid
  output logic [OutW-1:0]                           m_axis_tdata
);
  import otfm_pkg::*;

  localparam logic signed [TEMP_WIDTH-1:0] TempMax = {1'b0, {(TEMP_WIDTH-1){1'b1}}};

  // Configuration registers
  logic signed [TEMP_WIDTH-1:0] limit_q [NUM_FAULTS];
  logic signed [TEMP_WIDTH-1:0] stove_thr_q;
  logic [TIME_WIDTH-1:0]        delay_q;
  logic                         pellet_q;

  // Input register
  logic                         in_vld_q;
  logic [TIME_WIDTH-1:0]        now_q;
  logic signed [TEMP_WIDTH-1:0] temp_q [NUM_FAULTS];
  logic [NUM_FAULTS-1:0]        pres_q;
  logic signed [TEMP_WIDTH-1:0] stove_q;
  logic                         stove_pres_q;
  logic [1:0]                   valve_q;
  logic [NUM_FAULTS-1:0]        clr_q;

  // Result register
  logic                         out_vld_q;
  fault_state_e                 res_state_q [NUM_FAULTS];
  logic signed [TEMP_WIDTH-1:0] res_peak_q  [NUM_FAULTS];
  logic [NUM_FAULTS-1:0]        res_known_q;

  logic                         s_fire;
  logic                         out_free;
  logic                         advance;
  logic                         stove_hot;
  logic [NUM_FAULTS-1:0]        fire;
  fault_state_e                 state_n [NUM_FAULTS];
  logic signed [TEMP_WIDTH-1:0] peak_n  [NUM_FAULTS];
  logic [NUM_FAULTS-1:0]        known_n;

  assign out_free      = !out_vld_q || m_axis_tready;
  assign advance       = in_vld_q && out_free;
  assign s_axis_tready = !in_vld_q || out_free;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q[0]  <= TempMax;
      limit_q[1]  <= TempMax;
      limit_q[2]  <= TempMax;
      stove_thr_q <= TempMax;
      delay_q     <= '0;
      pellet_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ELEK_LIMIT:      limit_q[0]  <= cfg_data_i[TEMP_WIDTH-1:0];
        CFG_FLOOR1_LIMIT:    limit_q[1]  <= cfg_data_i[TEMP_WIDTH-1:0];
        CFG_FLOOR2_LIMIT:    limit_q[2]  <= cfg_data_i[TEMP_WIDTH-1:0];
        CFG_STOVE_THRESHOLD: stove_thr_q <= cfg_data_i[TEMP_WIDTH-1:0];
        CFG_FAULT_DELAY:     delay_q     <= cfg_data_i[TIME_WIDTH-1:0];
        CFG_PELLET_MODE:     pellet_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_fire) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      now_q        <= s_axis_tdata[TIME_WIDTH-1:0];
      temp_q[0]    <= s_axis_tdata[TIME_WIDTH +: TEMP_WIDTH];
      pres_q[0]    <= s_axis_tdata[TIME_WIDTH + TEMP_WIDTH];
      temp_q[1]    <= s_axis_tdata[TIME_WIDTH + (TEMP_WIDTH + 1) +: TEMP_WIDTH];
      pres_q[1]    <= s_axis_tdata[TIME_WIDTH + 2 * TEMP_WIDTH + 1];
      temp_q[2]    <= s_axis_tdata[TIME_WIDTH + 2 * (TEMP_WIDTH + 1) +: TEMP_WIDTH];
      pres_q[2]    <= s_axis_tdata[TIME_WIDTH + 3 * TEMP_WIDTH + 2];
      stove_q      <= s_axis_tdata[TIME_WIDTH + 3 * (TEMP_WIDTH + 1) +: TEMP_WIDTH];
      stove_pres_q <= s_axis_tdata[TIME_WIDTH + 4 * TEMP_WIDTH + 3];
      valve_q      <= s_axis_tdata[TIME_WIDTH + 4 * (TEMP_WIDTH + 1) +: 2];
      clr_q        <= s_axis_tdata[TIME_WIDTH + 4 * (TEMP_WIDTH + 1) + 2 +: NUM_FAULTS];
    end
  end

  assign stove_hot = stove_pres_q && (stove_q > stove_thr_q);
  assign fire[0]   = 1'b0;

  for (genvar t = 0; t < 2; t++) begin : g_timer
    otfm_timer #(
      .TIME_WIDTH(TIME_WIDTH)
    ) u_timer (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .update_i(advance),
      .enable_i(pellet_q),
      .cond_i  (valve_q[t] && stove_hot),
      .now_i   (now_q),
      .delay_i (delay_q),
      .fire_o  (fire[t+1])
    );
  end

  for (genvar c = 0; c < NUM_FAULTS; c++) begin : g_chan
    chan_ctrl_t ctrl;

    assign ctrl = '{update: advance, clear: clr_q[c], present: pres_q[c], fire: fire[c]};

    otfm_channel #(
      .TEMP_WIDTH(TEMP_WIDTH)
    ) u_chan (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .temp_i (temp_q[c]),
      .limit_i(limit_q[c]),
      .state_o(state_n[c]),
      .peak_o (peak_n[c]),
      .known_o(known_n[c])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_state_q <= state_n;
      res_peak_q  <= peak_n;
      res_known_q <= known_n;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = OutW'({res_known_q,
                                res_peak_q[2], res_peak_q[1], res_peak_q[0],
                                res_state_q[2], res_state_q[1], res_state_q[0]});

endmodule

`default_nettype wire

FILE: design/otfm_timer.sv
// Delay-on timer that watches one valve condition against the time counter.
`default_nettype none

module otfm_timer #(
  parameter int TIME_WIDTH = otfm_pkg::TIME_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  update_i,
  input  wire logic                  enable_i,
  input  wire logic                  cond_i,
  input  wire logic [TIME_WIDTH-1:0] now_i,
  input  wire logic [TIME_WIDTH-1:0] delay_i,
  output logic                       fire_o
);
  import otfm_pkg::*;

  logic [TIME_WIDTH-1:0] start_q, start_d;
  logic [TIME_WIDTH:0]   deadline;

  // The deadline is one bit wider so that it never wraps.
  assign deadline = {1'b0, start_q} + {1'b0, delay_i};
  assign fire_o   = enable_i && cond_i && ({1'b0, now_i} >= deadline);

  always_comb begin
    start_d = start_q;
    if (update_i && enable_i && !cond_i) begin
      start_d = now_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
    end else begin
      start_q <= start_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/otfm_channel.sv
// One fault channel: band check, three-state fault tracking and peak capture.
`default_nettype none

module otfm_channel #(
  parameter int TEMP_WIDTH = otfm_pkg::TEMP_WIDTH_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire otfm_pkg::chan_ctrl_t         ctrl_i,
  input  wire logic signed [TEMP_WIDTH-1:0] temp_i,
  input  wire logic signed [TEMP_WIDTH-1:0] limit_i,
  output otfm_pkg::fault_state_e            state_o,
  output logic signed [TEMP_WIDTH-1:0]      peak_o,
  output logic                              known_o
);
  import otfm_pkg::*;

  localparam logic signed [TEMP_WIDTH-1:0] LowBand = TEMP_WIDTH'(LOW_BAND);

  fault_state_e                  state_q, state_d, state_c;
  logic signed [TEMP_WIDTH-1:0]  peak_q, peak_d, peak_c;
  logic                          known_q, known_d, known_c;
  logic                          fault;
  logic                          take;

  assign fault = !ctrl_i.present || (temp_i < LowBand) || (temp_i > limit_i) || ctrl_i.fire;

  always_comb begin
    state_c = ctrl_i.clear ? FS_INACTIVE : state_q;
    peak_c  = ctrl_i.clear ? '0 : peak_q;
    known_c = ctrl_i.clear ? 1'b0 : known_q;

    if (fault) begin
      state_d = FS_ACTIVE;
    end else if (state_c == FS_ACTIVE) begin
      state_d = FS_PRESENT;
    end else begin
      state_d = state_c;
    end

    take    = (state_d == FS_ACTIVE) && ctrl_i.present && (!known_c || (temp_i > peak_c));
    peak_d  = take ? temp_i : peak_c;
    known_d = known_c || take;
  end

  assign state_o = state_d;
  assign peak_o  = peak_d;
  assign known_o = known_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_INACTIVE;
      peak_q  <= '0;
      known_q <= 1'b0;
    end else if (ctrl_i.update) begin
      state_q <= state_d;
      peak_q  <= peak_d;
      known_q <= known_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/otfm_checker.sv
// Port-level checks for the over-temperature fault monitor, bound to the top level.
`default_nettype none

module otfm_checker #(
  parameter int TEMP_WIDTH = otfm_pkg::TEMP_WIDTH_DEF,
  parameter int OutW       = 64
) (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            s_axis_tready,
  input wire logic            m_axis_tvalid,
  input wire logic            m_axis_tready,
  input wire logic [OutW-1:0] m_axis_tdata
);
  import otfm_pkg::*;

  localparam int PeakLsb  = 2 * NUM_FAULTS;
  localparam int ValidLsb = PeakLsb + NUM_FAULTS * TEMP_WIDTH;

  // A stalled result holds its value until it is taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // With the result register empty the input side must be open.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input blocked with empty result register");

  // The elek peak without its valid mark reads as zero.
  a_peak_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[ValidLsb] |-> m_axis_tdata[PeakLsb +: TEMP_WIDTH] == '0)
    else $error("elek peak non-zero without valid mark");

  // An inactive floor1 fault cannot hold a peak; peaks are recorded only while active.
  a_inactive_nopeak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3:2] == FS_INACTIVE |-> !m_axis_tdata[ValidLsb + 1])
    else $error("floor1 inactive with a recorded peak");

endmodule

bind overtemp_fault_monitor otfm_checker #(
  .TEMP_WIDTH(TEMP_WIDTH),
  .OutW      (OutW)
) u_otfm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

`default_nettype wire
